// ----- design/pksw_pkg.sv -----
// ----------------------------------------------------------------------------
// pksw_pkg
// Shared constants for the per-key sighting window counter.
// ----------------------------------------------------------------------------
package pksw_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned RingSlotsDef    = 32;
  localparam logic [31:0] WindowReset     = 32'd500000;
  localparam int unsigned CountW          = 6;
  localparam logic [CountW-1:0] CountMax  = 6'd63;

endpackage

// ----- design/pksw_in_if.sv -----
// ----------------------------------------------------------------------------
// pksw_in_if
// Sighting channel: valid/ready with reader, tag and time.
// ----------------------------------------------------------------------------
interface pksw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] reader;
  logic [31:0] tag;
  logic [31:0] now_us;

  modport source (output valid, output reader, output tag, output now_us, input ready);
  modport sink   (input valid, input reader, input tag, input now_us, output ready);
endinterface

// ----- design/pksw_out_if.sv -----
// ----------------------------------------------------------------------------
// pksw_out_if
// Result channel: valid/ready with reader, tag and recent count.
// ----------------------------------------------------------------------------
interface pksw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_reader;
  logic [31:0] out_tag;
  logic [5:0]  recent_count;

  modport source (output valid, output out_reader, output out_tag, output recent_count,
                  input ready);
  modport sink   (input valid, input out_reader, input out_tag, input recent_count,
                  output ready);
endinterface

// ----- design/pksw_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pksw_cfg_if
// Configuration write channel carrying the window register value.
// ----------------------------------------------------------------------------
interface pksw_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/per_key_sighting_window_counter_core.sv -----
// ----------------------------------------------------------------------------
// per_key_sighting_window_counter_core
// Key lookup in a table memory, then write of the time into the entry's ring
// and a scan of the ring slots against the window.
// The key search reads one table entry per cycle and the ring scan reads one
// ring slot per cycle. One word in flight at a time; the next is taken only
// after the result word has been accepted, so later while the result waits;
// a word dropped on a full table frees the input once the key search ends.
// Reset: asynchronous, clears the fill count, window to 500000, FSM to idle.
// ----------------------------------------------------------------------------
module per_key_sighting_window_counter_core
  import pksw_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned RING_SLOTS    = RingSlotsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pksw_in_if.sink      in_i,
  pksw_out_if.source   out_o,
  pksw_cfg_if.sink     cfg_i
);

  localparam int unsigned EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int unsigned EC = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SC = $clog2(RING_SLOTS + 1);
  localparam int unsigned CW = $clog2(RING_SLOTS + 1);
  localparam int unsigned AW = EW + SW;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_WRITE, S_STORE, S_SCAN, S_DONE, S_OUT
  } state_e;

  state_e state_q;

  // memories; pos_mem holds {ring full, ring position} per entry
  logic [47:0] key_mem  [TABLE_ENTRIES];
  logic [SW:0] pos_mem  [TABLE_ENTRIES];
  logic [31:0] time_mem [TABLE_ENTRIES*RING_SLOTS];

  logic [31:0] window_q;
  logic [15:0] reader_q;
  logic [31:0] tag_q, now_q;
  logic [EC-1:0] sidx_q;
  logic [EC-1:0] fill_q;   // entries in use; they always form a prefix
  logic [EW-1:0] ent_q;
  logic          hit_q;
  logic [47:0]   key_rd_q;
  logic          rd_pend_q;
  logic [EW-1:0] rd_idx_q;
  logic [SC-1:0] scnt_q;
  logic          srd_pend_q;
  logic [SW-1:0] sslot_q;
  logic [31:0]   time_rd_q;
  logic [CW-1:0] count_q;
  logic [SW-1:0] pos_q;
  logic          full_q;
  logic [SW:0]   pos_rd_q;
  logic          new_q;
  logic [CountW-1:0] res_cnt_q;

  assign in_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = (state_q == S_OUT);
  assign out_o.out_reader    = reader_q;
  assign out_o.out_tag       = tag_q;
  assign out_o.recent_count  = res_cnt_q;

  // advance the ring position with wrap
  logic          ring_wrap;
  logic [SW-1:0] pos_next;
  assign ring_wrap = (pos_q == SW'(RING_SLOTS - 1));
  assign pos_next  = ring_wrap ? '0 : pos_q + 1'b1;

  // key and position memories
  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[sidx_q[EW-1:0]];
    pos_rd_q <= pos_mem[ent_q];
    if (state_q == S_WRITE && new_q) begin
      key_mem[ent_q] <= {reader_q, tag_q};
    end
    if (state_q == S_DONE) begin
      pos_mem[ent_q] <= {full_q | ring_wrap, pos_next};
    end
  end

  // ring memory
  logic [AW-1:0] waddr, raddr;
  assign waddr = AW'(ent_q) * AW'(RING_SLOTS) + AW'(pos_q);
  assign raddr = AW'(ent_q) * AW'(RING_SLOTS) + AW'(sslot_q);
  always_ff @(posedge clk_i) begin
    if (state_q == S_STORE) begin
      time_mem[waddr] <= now_q;
    end
    time_rd_q <= time_mem[raddr];
  end

  // a slot holds a sighting once the ring has wrapped or up to the write slot
  logic [SW-1:0] eval_slot;
  logic          slot_live;
  logic [31:0]   age;
  assign eval_slot = SW'(scnt_q - 1'b1);
  assign slot_live = full_q || (eval_slot <= pos_q);
  assign age       = now_q - time_rd_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      window_q   <= WindowReset;
      reader_q   <= '0;
      tag_q      <= '0;
      now_q      <= '0;
      sidx_q     <= '0;
      ent_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_idx_q   <= '0;
      srd_pend_q <= 1'b0;
      scnt_q     <= '0;
      sslot_q    <= '0;
      count_q    <= '0;
      pos_q      <= '0;
      full_q     <= 1'b0;
      hit_q      <= 1'b0;
      new_q      <= 1'b0;
      res_cnt_q  <= '0;
    end else begin
      if (cfg_i.valid) window_q <= cfg_i.data;
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            reader_q  <= in_i.reader;
            tag_q     <= in_i.tag;
            now_q     <= in_i.now_us;
            sidx_q    <= '0;
            rd_pend_q <= 1'b0;
            hit_q     <= 1'b0;
            state_q   <= S_SEARCH;
          end
        end
        // walk entries, one read per cycle, check each result in the next cycle
        S_SEARCH: begin
          if (rd_pend_q && (EC'(rd_idx_q) < fill_q) && key_rd_q == {reader_q, tag_q}) begin
            hit_q <= 1'b1;
            ent_q <= rd_idx_q;
          end
          if (sidx_q < EC'(TABLE_ENTRIES)) begin
            rd_pend_q <= 1'b1;
            rd_idx_q  <= sidx_q[EW-1:0];
            sidx_q    <= sidx_q + 1'b1;
          end else if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
          end else if (hit_q) begin
            new_q     <= 1'b0;
            rd_pend_q <= 1'b1;
            state_q   <= S_WRITE;
          end else if (fill_q < EC'(TABLE_ENTRIES)) begin
            new_q     <= 1'b1;
            ent_q     <= fill_q[EW-1:0];
            fill_q    <= fill_q + 1'b1;
            rd_pend_q <= 1'b1;
            state_q   <= S_WRITE;
          end else begin
            state_q <= S_IDLE;
          end
        end
        // position read while the read is pending, then take position and full flag
        S_WRITE: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
          end else begin
            pos_q   <= new_q ? '0 : pos_rd_q[SW-1:0];
            full_q  <= new_q ? 1'b0 : pos_rd_q[SW];
            state_q <= S_STORE;
          end
        end
        // store the time in the ring, then start the scan
        S_STORE: begin
          sslot_q    <= '0;
          scnt_q     <= '0;
          srd_pend_q <= 1'b0;
          count_q    <= '0;
          state_q    <= S_SCAN;
        end
        S_SCAN: begin
          srd_pend_q <= (scnt_q < SC'(RING_SLOTS));
          if (scnt_q < SC'(RING_SLOTS)) begin
            scnt_q  <= scnt_q + 1'b1;
            sslot_q <= (scnt_q == SC'(RING_SLOTS - 1)) ? sslot_q : sslot_q + 1'b1;
          end
          if (srd_pend_q && slot_live && age < window_q)
            count_q <= count_q + 1'b1;
          if (!srd_pend_q && scnt_q == SC'(RING_SLOTS)) state_q <= S_DONE;
        end
        S_DONE: begin
          res_cnt_q <= (count_q > CW'(CountMax)) ? CountMax : CountW'(count_q);
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (out_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/pksw_bench_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pksw_bench_if
// Bench-side handle on the sighting, result and window channels, so that the
// checker can watch all three from one port.
// ----------------------------------------------------------------------------
interface pksw_bench_if;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_reader;
  logic [31:0] in_tag;
  logic [31:0] in_now_us;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_reader;
  logic [31:0] out_tag;
  logic [5:0]  out_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  modport monitor (input in_valid, in_ready, in_reader, in_tag, in_now_us,
                   out_valid, out_ready, out_reader, out_tag, out_count,
                   cfg_valid, cfg_ready, cfg_data);
endinterface

// ----- bench/pksw_window_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pksw_window_checker
// Tracks the key table and the timestamp rings of each accepted sighting,
// predicts the recent count, and compares every result word against it.
// ----------------------------------------------------------------------------
module pksw_window_checker
  import pksw_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned RING_SLOTS    = RingSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pksw_bench_if.monitor      mon_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        results_seen_o,
  output int unsigned        full_drops_o
);

  typedef struct packed {
    logic [15:0]       reader;
    logic [31:0]       tag;
    logic [CountW-1:0] count;
  } sighting_result_t;

  logic [47:0]       key_tab   [TABLE_ENTRIES];
  logic              key_used  [TABLE_ENTRIES];
  int unsigned       ring_next [TABLE_ENTRIES];
  logic [31:0]       ring_time [TABLE_ENTRIES][RING_SLOTS];
  logic              ring_live [TABLE_ENTRIES][RING_SLOTS];
  logic [31:0]       window_cur;
  sighting_result_t  expected_results[$];

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR %s", $realtime, what);
    fail_count_o++;
  endtask

  // Update the table for one sighting and queue the expected count.
  task automatic predict_sighting(input logic [15:0] rd, input logic [31:0] tg,
                                  input logic [31:0] now);
    int hit;
    int free_e;
    int unsigned cnt;
    logic [31:0] age;
    sighting_result_t res;
    hit = -1;
    free_e = -1;
    cnt = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (key_used[i]) begin
        if (hit < 0 && key_tab[i] == {rd, tg}) hit = i;
      end else if (free_e < 0) begin
        free_e = i;
      end
    end
    if (hit < 0) begin
      if (free_e < 0) begin
        full_drops_o++;
        return;
      end
      hit = free_e;
      key_used[hit] = 1'b1;
      key_tab[hit] = {rd, tg};
      ring_next[hit] = 0;
      for (int s = 0; s < RING_SLOTS; s++) ring_live[hit][s] = 1'b0;
    end
    ring_time[hit][ring_next[hit]] = now;
    ring_live[hit][ring_next[hit]] = 1'b1;
    ring_next[hit] = (ring_next[hit] + 1) % RING_SLOTS;
    for (int s = 0; s < RING_SLOTS; s++) begin
      age = now - ring_time[hit][s];
      if (ring_live[hit][s] && age < window_cur) cnt++;
    end
    if (cnt > CountMax) cnt = CountMax;
    res.reader = rd;
    res.tag = tg;
    res.count = cnt[CountW-1:0];
    expected_results.push_back(res);
  endtask

  // Watch all channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    sighting_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        key_used[i] = 1'b0;
        ring_next[i] = 0;
        for (int s = 0; s < RING_SLOTS; s++) ring_live[i][s] = 1'b0;
      end
      window_cur = WindowReset;
      expected_results.delete();
      fail_count_o = 0;
      results_seen_o = 0;
      full_drops_o = 0;
    end else begin
      if (mon_i.cfg_valid && mon_i.cfg_ready) window_cur = mon_i.cfg_data;
      if (mon_i.out_valid && mon_i.out_ready) begin
        results_seen_o++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word reader=%h tag=%h",
                                    mon_i.out_reader, mon_i.out_tag));
        end else begin
          exp_r = expected_results.pop_front();
          if (mon_i.out_reader !== exp_r.reader)
            report_mismatch($sformatf("reader got %h want %h", mon_i.out_reader,
                                      exp_r.reader));
          if (mon_i.out_tag !== exp_r.tag)
            report_mismatch($sformatf("tag got %h want %h", mon_i.out_tag, exp_r.tag));
          if (mon_i.out_count !== exp_r.count)
            report_mismatch($sformatf("count got %0d want %0d (reader %h tag %h)",
                                      mon_i.out_count, exp_r.count, exp_r.reader,
                                      exp_r.tag));
        end
      end
      if (mon_i.in_valid && mon_i.in_ready)
        predict_sighting(mon_i.in_reader, mon_i.in_tag, mon_i.in_now_us);
    end
  end

endmodule

// ----- bench/per_key_sighting_window_counter_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_key_sighting_window_counter_core_test
// Drives sightings and window writes into the counter core with random
// stalls on both sides; a checker beside the block predicts every count.
// ----------------------------------------------------------------------------
module per_key_sighting_window_counter_core_test;
  import pksw_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainWait  = 2 * (TableEntriesDef + RingSlotsDef + 5);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic calm = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_count, pending, results_seen, full_drops, words_sent;
  logic [15:0] pool_reader[8];
  logic [31:0] pool_tag[8];
  logic [31:0] clock_us;

  pksw_in_if    in_ch();
  pksw_out_if   out_ch();
  pksw_cfg_if   cfg_ch();
  pksw_bench_if mon();

  assign mon.in_valid   = in_ch.valid;
  assign mon.in_ready   = in_ch.ready;
  assign mon.in_reader  = in_ch.reader;
  assign mon.in_tag     = in_ch.tag;
  assign mon.in_now_us  = in_ch.now_us;
  assign mon.out_valid  = out_ch.valid;
  assign mon.out_ready  = out_ch.ready;
  assign mon.out_reader = out_ch.out_reader;
  assign mon.out_tag    = out_ch.out_tag;
  assign mon.out_count  = out_ch.recent_count;
  assign mon.cfg_valid  = cfg_ch.valid;
  assign mon.cfg_ready  = cfg_ch.ready;
  assign mon.cfg_data   = cfg_ch.data;

  per_key_sighting_window_counter_core u_top (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  pksw_window_checker u_check (
    .clk_i(clk_i), .rst_ni(rst_ni), .mon_i(mon), .fail_count_o(fail_count),
    .pending_o(pending), .results_seen_o(results_seen), .full_drops_o(full_drops)
  );

  always #4 clk_i = ~clk_i;

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("per_key_sighting_window_counter_core: mismatch");
      $finish;
    end
  end

  // Result side: stall in bursts, none once calm.
  initial begin
    int unsigned hold;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_window(input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Send one sighting, with an optional idle burst before it.
  task automatic send_word(input logic [15:0] rd, input logic [31:0] tg,
                           input logic [31:0] now);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.reader <= rd;
    in_ch.tag    <= tg;
    in_ch.now_us <= now;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // Mostly repeated keys with advancing time, some fresh keys and noise.
  task automatic random_phase(input int unsigned n);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        clock_us += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000);
        send_word(pool_reader[pick % 8], pool_tag[pick % 8], clock_us);
      end else if (pick < 90) begin
        send_word(16'($urandom), $urandom, $urandom);
      end else begin
        send_word(pool_reader[pick % 8], pool_tag[pick % 8], $urandom);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.reader = '0;
    in_ch.tag = '0;
    in_ch.now_us = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    words_sent = 0;
    clock_us = $urandom;
    for (int i = 0; i < 8; i++) begin
      pool_reader[i] = 16'($urandom);
      pool_tag[i] = $urandom;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, reset window, wrapped age, repeated sightings of one key.
    send_word(16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_word(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0010);
    send_word(16'h0000, 32'h0000_0000, 32'h0007_A11F);
    send_word(16'h0000, 32'h0000_0000, 32'h0007_A120);
    send_word(16'h0000, 32'h0000_0000, 32'h0000_0005);
    for (int i = 0; i < 16; i++) send_word(16'h1234, 32'hCAFE_0001, 32'(i * 10));
    drain_results();

    // Zero window: nothing counts.
    write_window(32'h0000_0000);
    send_word(16'h1234, 32'hCAFE_0001, 32'd200);
    drain_results();
    // Widest window: full ring counted, overflow of slots.
    write_window(32'hFFFF_FFFF);
    for (int i = 0; i < 20; i++) send_word(16'h1234, 32'hCAFE_0001, 32'(300 + i));
    random_phase(300);
    drain_results();
    write_window(32'd1);
    random_phase(200);
    drain_results();
    write_window(32'd250000);
    random_phase(300);
    // Fill the table with fresh keys so that new ones are dropped.
    for (int i = 0; i < 70; i++) send_word(16'(i), 32'hA5A5_0000 + i, $urandom);
    drain_results();
    write_window($urandom);
    random_phase(150);
    drain_results();
    write_window(WindowReset);
    calm = 1'b1;
    random_phase(200);
    drain_results();

    $display("sent %0d sightings, checked %0d results, %0d dropped on a full table",
             words_sent, results_seen, full_drops);
    if (fail_count == 0) begin
      $display("per_key_sighting_window_counter_core: match");
    end else begin
      $display("per_key_sighting_window_counter_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- per_key_sighting_window_counter_core.f -----
design/pksw_pkg.sv
design/pksw_in_if.sv
design/pksw_out_if.sv
design/pksw_cfg_if.sv
design/per_key_sighting_window_counter_core.sv
bench/pksw_bench_if.sv
bench/pksw_window_checker.sv
bench/per_key_sighting_window_counter_core_test.sv
